@@ hw/rtl/gdtdn_pkg.sv @@
// ============================================================================
// gdtdn_pkg
// Shared types, constants and calendar tables for the Gregorian date to
// day-number pipeline.
// ============================================================================
package gdtdn_pkg;

    localparam int unsigned MONTH_BITS     = 4;
    localparam int unsigned DAY_BITS       = 5;
    localparam int unsigned MLEN_BITS      = 5;
    localparam int unsigned DBM_BITS       = 9;
    localparam int unsigned DAY_COUNT_BITS = 20;
    localparam int unsigned WEEKDAY_BITS   = 3;

    // result beat: date_valid, leap_year, month_length, day_count, weekday
    localparam int unsigned RESULT_BITS =
        2 + MLEN_BITS + DAY_COUNT_BITS + WEEKDAY_BITS;
    localparam int unsigned RESULT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    localparam int unsigned EPOCH_YEAR          = 1800;
    localparam int unsigned EPOCH_WEEKDAY       = 3;
    // leap years in 1..1799
    localparam int unsigned LEAPS_BEFORE_EPOCH  = 436;
    localparam int unsigned DAYS_PER_YEAR       = 365;

    // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT, exact for x < 2^14
    localparam int unsigned DIV25_MUL_BITS = 13;
    localparam logic [DIV25_MUL_BITS-1:0] DIV25_MUL = 13'd5243;
    localparam int unsigned DIV25_SHIFT    = 17;

    // mod-7 folding works on a six-bit partial sum
    localparam int unsigned FOLD_BITS = 6;

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_BITS-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_BITS-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_BITS-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_BITS-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic                 date_valid;
        logic                 leap_year;
        logic [MLEN_BITS-1:0] month_length;
    } gdtdn_flags_t;

    // days in the month, zero for a month code outside January..December
    function automatic logic [MLEN_BITS-1:0] month_days(
        input logic [MONTH_BITS-1:0] month,
        input logic                  leap
    );
        logic [MLEN_BITS-1:0] len;
        unique case (month)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

    // days of a common year before the first of the month
    function automatic logic [DBM_BITS-1:0] days_before(
        input logic [MONTH_BITS-1:0] month
    );
        logic [DBM_BITS-1:0] dbm;
        unique case (month)
            MONTH_JAN: dbm = 9'd0;
            MONTH_FEB: dbm = 9'd31;
            MONTH_MAR: dbm = 9'd59;
            MONTH_APR: dbm = 9'd90;
            MONTH_MAY: dbm = 9'd120;
            MONTH_JUN: dbm = 9'd151;
            MONTH_JUL: dbm = 9'd181;
            MONTH_AUG: dbm = 9'd212;
            MONTH_SEP: dbm = 9'd243;
            MONTH_OCT: dbm = 9'd273;
            MONTH_NOV: dbm = 9'd304;
            MONTH_DEC: dbm = 9'd334;
            default:   dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage

@@ hw/rtl/gregorian_date_to_day_number.sv @@
// ============================================================================
// gregorian_date_to_day_number
// Checks a Gregorian date and returns its leap flag, month length, day count
// since 1800-01-01 and weekday.
// ============================================================================
// One date is taken per clock while the input stage is not held by a stall, and
// each result passes through the four register stages: a reciprocal multiply for
// the year's hundreds, the leap, length and validity logic, the day-count
// multiply-add, and the mod-7 fold in the output register. A stall on the
// result side holds only the stages that are full; empty stages keep taking
// beats. Dates before 1800, months outside 1..12 and days outside the month
// give date_valid low with day_count and weekday zero. day_count carries the
// low 20 bits of the count; the weekday uses the full count.
// ============================================================================
module gregorian_date_to_day_number #(
    parameter int unsigned YEAR_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // year_in, month_in, day_in, zero padding
    input  logic [((YEAR_BITS + gdtdn_pkg::MONTH_BITS + gdtdn_pkg::DAY_BITS + 7) / 8) * 8 - 1:0]
                 s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // date_valid, leap_year, month_length, day_count, weekday, zero padding
    output logic [gdtdn_pkg::RESULT_TDATA_BITS-1:0] m_tdata
);
    import gdtdn_pkg::*;

    localparam int unsigned CNT_BITS  = YEAR_BITS + 9;
    localparam int unsigned MONTH_LSB = YEAR_BITS;
    localparam int unsigned DAY_LSB   = YEAR_BITS + MONTH_BITS;

    logic                    yr_valid;
    logic                    yr_ready;
    gdtdn_flags_t            yr_flags;
    logic [MONTH_BITS-1:0]   yr_month;
    logic [DAY_BITS-1:0]     yr_day;
    logic [YEAR_BITS-1:0]    yr_offset;
    logic [YEAR_BITS-3:0]    yr_leaps;

    logic                    cnt_valid;
    logic                    cnt_ready;
    gdtdn_flags_t            cnt_flags;
    logic [CNT_BITS-1:0]     cnt_count;

    gdtdn_flags_t              res_flags;
    logic [DAY_COUNT_BITS-1:0] res_count;
    logic [WEEKDAY_BITS-1:0]   res_wday;

    gdtdn_year_unit #(
        .YEAR_BITS (YEAR_BITS)
    ) u_year (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .year        (s_tdata[YEAR_BITS-1:0]),
        .month       (s_tdata[MONTH_LSB +: MONTH_BITS]),
        .day         (s_tdata[DAY_LSB +: DAY_BITS]),
        .out_valid   (yr_valid),
        .out_ready   (yr_ready),
        .flags       (yr_flags),
        .month_out   (yr_month),
        .day_out     (yr_day),
        .year_offset (yr_offset),
        .leaps_since (yr_leaps)
    );

    gdtdn_count_unit #(
        .YEAR_BITS (YEAR_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (yr_valid),
        .in_ready    (yr_ready),
        .flags       (yr_flags),
        .month       (yr_month),
        .day         (yr_day),
        .year_offset (yr_offset),
        .leaps_since (yr_leaps),
        .out_valid   (cnt_valid),
        .out_ready   (cnt_ready),
        .flags_out   (cnt_flags),
        .count       (cnt_count)
    );

    gdtdn_wday_unit #(
        .CNT_BITS (CNT_BITS)
    ) u_wday (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cnt_valid),
        .in_ready  (cnt_ready),
        .flags     (cnt_flags),
        .count     (cnt_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .flags_out (res_flags),
        .day_count (res_count),
        .weekday   (res_wday)
    );

    assign m_tdata = RESULT_TDATA_BITS'({res_wday, res_count, res_flags.month_length,
                                         res_flags.leap_year, res_flags.date_valid});

    // an invalid date never carries a count or weekday
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !res_flags.date_valid) |-> (res_count == '0 && res_wday == '0))
        else $error("invalid date with non-zero count or weekday");

    a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_wday != 3'd7))
        else $error("weekday out of range");

    a_valid_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_flags.date_valid) |-> (res_flags.month_length >= 5'd28))
        else $error("valid date with impossible month length");

    a_feb29_leap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_flags.month_length == 5'd29) |-> res_flags.leap_year)
        else $error("29-day month in a common year");

endmodule

@@ hw/rtl/gdtdn_year_unit.sv @@
// ============================================================================
// gdtdn_year_unit
// Two pipeline stages on the year: divide by 100 through a reciprocal
// multiply, then the leap flag, month length, validity and leap-year count.
// ============================================================================
module gdtdn_year_unit #(
    parameter int unsigned YEAR_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [YEAR_BITS-1:0]              year,
    input  logic [gdtdn_pkg::MONTH_BITS-1:0]  month,
    input  logic [gdtdn_pkg::DAY_BITS-1:0]    day,
    output logic                              out_valid,
    input  logic                              out_ready,
    output gdtdn_pkg::gdtdn_flags_t           flags,
    output logic [gdtdn_pkg::MONTH_BITS-1:0]  month_out,
    output logic [gdtdn_pkg::DAY_BITS-1:0]    day_out,
    output logic [YEAR_BITS-1:0]              year_offset,
    output logic [YEAR_BITS-3:0]              leaps_since
);
    import gdtdn_pkg::*;

    localparam int unsigned QTR_BITS  = YEAR_BITS - 2;
    localparam int unsigned PROD_BITS = QTR_BITS + DIV25_MUL_BITS;
    localparam int unsigned Q_BITS    = PROD_BITS - DIV25_SHIFT;

    // stage A registers
    logic                     a_valid_reg;
    logic [YEAR_BITS-1:0]     a_year_reg;
    logic [MONTH_BITS-1:0]    a_month_reg;
    logic [DAY_BITS-1:0]      a_day_reg;
    logic [PROD_BITS-1:0]     a_prod_reg;
    logic [PROD_BITS-1:0]     a_prod_next;
    logic                     a_ready;

    // stage B registers
    logic                     b_valid_reg;
    gdtdn_flags_t             b_flags_reg;
    gdtdn_flags_t             b_flags_next;
    logic [MONTH_BITS-1:0]    b_month_reg;
    logic [DAY_BITS-1:0]      b_day_reg;
    logic [YEAR_BITS-1:0]     b_offset_reg;
    logic [YEAR_BITS-1:0]     b_offset_next;
    logic [QTR_BITS-1:0]      b_leaps_reg;
    logic [QTR_BITS-1:0]      b_leaps_next;
    logic                     b_ready;

    // stage B working values
    logic [QTR_BITS-1:0]      quarter;
    logic [Q_BITS-1:0]        hundreds;
    logic [QTR_BITS-1:0]      hundreds_x25;
    logic                     leap;
    logic [MLEN_BITS-1:0]     mlen;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_prod_next = PROD_BITS'(year[YEAR_BITS-1:2]) * PROD_BITS'(DIV25_MUL);

    always_comb
    begin
        quarter      = a_year_reg[YEAR_BITS-1:2];
        hundreds     = a_prod_reg[PROD_BITS-1:DIV25_SHIFT];
        hundreds_x25 = QTR_BITS'(hundreds) * QTR_BITS'(25);
        // divisible by 4, and either not by 100 or also by 400
        leap = (a_year_reg[1:0] == 2'd0)
            && ((quarter != hundreds_x25) || (hundreds[1:0] == 2'd0));
        mlen = month_days(a_month_reg, leap);

        b_flags_next.leap_year    = leap;
        b_flags_next.month_length = mlen;
        b_flags_next.date_valid   = (a_year_reg >= YEAR_BITS'(EPOCH_YEAR))
            && (mlen != '0) && (a_day_reg != '0)
            && (a_day_reg <= mlen);

        b_offset_next = a_year_reg - YEAR_BITS'(EPOCH_YEAR);
        // leap years in 1800..year-1, wraps harmlessly on invalid dates
        b_leaps_next = quarter - QTR_BITS'(hundreds) + QTR_BITS'(hundreds >> 2)
            - QTR_BITS'(leap) - QTR_BITS'(LEAPS_BEFORE_EPOCH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_year_reg  <= year;
            a_month_reg <= month;
            a_day_reg   <= day;
            a_prod_reg  <= a_prod_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_flags_reg  <= b_flags_next;
            b_month_reg  <= a_month_reg;
            b_day_reg    <= a_day_reg;
            b_offset_reg <= b_offset_next;
            b_leaps_reg  <= b_leaps_next;
        end
    end

    assign out_valid   = b_valid_reg;
    assign flags       = b_flags_reg;
    assign month_out   = b_month_reg;
    assign day_out     = b_day_reg;
    assign year_offset = b_offset_reg;
    assign leaps_since = b_leaps_reg;

endmodule

@@ hw/rtl/gdtdn_count_unit.sv @@
// ============================================================================
// gdtdn_count_unit
// Pipeline stage that forms the full day count since the epoch: whole years,
// leap days, days before the month and the day itself.
// ============================================================================
module gdtdn_count_unit #(
    parameter int unsigned YEAR_BITS = 12,
    parameter int unsigned CNT_BITS  = 21
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  gdtdn_pkg::gdtdn_flags_t           flags,
    input  logic [gdtdn_pkg::MONTH_BITS-1:0]  month,
    input  logic [gdtdn_pkg::DAY_BITS-1:0]    day,
    input  logic [YEAR_BITS-1:0]              year_offset,
    input  logic [YEAR_BITS-3:0]              leaps_since,
    output logic                              out_valid,
    input  logic                              out_ready,
    output gdtdn_pkg::gdtdn_flags_t           flags_out,
    output logic [CNT_BITS-1:0]               count
);
    import gdtdn_pkg::*;

    logic                 valid_reg;
    gdtdn_flags_t         flags_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic                 leap_day;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        leap_day   = flags.leap_year && (month > MONTH_FEB);
        count_next = CNT_BITS'(year_offset) * CNT_BITS'(DAYS_PER_YEAR)
            + CNT_BITS'(leaps_since)
            + CNT_BITS'(days_before(month))
            + CNT_BITS'(leap_day)
            + CNT_BITS'(day) - CNT_BITS'(1);
        // invalid dates report a zero count
        if (!flags.date_valid)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            flags_reg <= flags;
            count_reg <= count_next;
        end
    end

    assign out_valid = valid_reg;
    assign flags_out = flags_reg;
    assign count     = count_reg;

endmodule

@@ hw/rtl/gdtdn_wday_unit.sv @@
// ============================================================================
// gdtdn_wday_unit
// Output stage: weekday by folding octal digits of the count (8 = 1 mod 7),
// and the result register that faces the downstream side.
// ============================================================================
module gdtdn_wday_unit #(
    parameter int unsigned CNT_BITS = 21
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  gdtdn_pkg::gdtdn_flags_t              flags,
    input  logic [CNT_BITS-1:0]                  count,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output gdtdn_pkg::gdtdn_flags_t              flags_out,
    output logic [gdtdn_pkg::DAY_COUNT_BITS-1:0] day_count,
    output logic [gdtdn_pkg::WEEKDAY_BITS-1:0]   weekday
);
    import gdtdn_pkg::*;

    localparam int unsigned NDIG     = (CNT_BITS + 3) / 3;
    localparam int unsigned EXT_BITS = 3 * NDIG;

    logic                       valid_reg;
    gdtdn_flags_t               flags_reg;
    logic [DAY_COUNT_BITS-1:0]  count_reg;
    logic [WEEKDAY_BITS-1:0]    wday_reg;
    logic [WEEKDAY_BITS-1:0]    wday_next;

    logic [EXT_BITS-1:0]        shifted;
    logic [FOLD_BITS-1:0]       digit_sum;
    logic [3:0]                 pair_sum;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        shifted   = EXT_BITS'(count) + EXT_BITS'(EPOCH_WEEKDAY);
        digit_sum = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            digit_sum = digit_sum + FOLD_BITS'(shifted[3*i +: 3]);
        end
        pair_sum = 4'(digit_sum[2:0]) + 4'(digit_sum[5:3]);
        priority if (pair_sum >= 4'd14)
        begin
            wday_next = 3'(pair_sum - 4'd14);
        end
        else if (pair_sum >= 4'd7)
        begin
            wday_next = 3'(pair_sum - 4'd7);
        end
        else
        begin
            wday_next = 3'(pair_sum);
        end
        if (!flags.date_valid)
        begin
            wday_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            flags_reg <= flags;
            count_reg <= count[DAY_COUNT_BITS-1:0];
            wday_reg  <= wday_next;
        end
    end

    assign out_valid = valid_reg;
    assign flags_out = flags_reg;
    assign day_count = count_reg;
    assign weekday   = wday_reg;

endmodule
